@@ design/uoi_pkg.sv @@
package uoi_pkg;
    localparam int POS_WIDTH_DEF    = 48;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_COUNT       = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [24:0] YAW_SCALE_Q16 = 25'd22399067;

    localparam logic [1:0] OP_CMD    = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_ENABLE = 2'd2;

    localparam logic [1:0] REG_LIN_LIMIT = 2'd0;
    localparam logic [1:0] REG_ANG_LIMIT = 2'd1;
    localparam logic [1:0] REG_TIMEOUT   = 2'd2;
    localparam logic [1:0] REG_MAX_STEP  = 2'd3;

    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic               done;
        logic signed [33:0] cos_v;
        logic signed [33:0] sin_v;
    } cordic_rsp_t;

    function automatic logic signed [33:0] atan_val(input logic [4:0] i);
        case (i)
            5'd0:  atan_val = 34'sd536870912;
            5'd1:  atan_val = 34'sd316933406;
            5'd2:  atan_val = 34'sd167458907;
            5'd3:  atan_val = 34'sd85004756;
            5'd4:  atan_val = 34'sd42667331;
            5'd5:  atan_val = 34'sd21354465;
            5'd6:  atan_val = 34'sd10679838;
            5'd7:  atan_val = 34'sd5340245;
            5'd8:  atan_val = 34'sd2670163;
            5'd9:  atan_val = 34'sd1335087;
            5'd10: atan_val = 34'sd667544;
            5'd11: atan_val = 34'sd333772;
            5'd12: atan_val = 34'sd166886;
            5'd13: atan_val = 34'sd83443;
            5'd14: atan_val = 34'sd41722;
            5'd15: atan_val = 34'sd20861;
            5'd16: atan_val = 34'sd10430;
            5'd17: atan_val = 34'sd5215;
            5'd18: atan_val = 34'sd2608;
            5'd19: atan_val = 34'sd1304;
            5'd20: atan_val = 34'sd652;
            5'd21: atan_val = 34'sd326;
            5'd22: atan_val = 34'sd163;
            5'd23: atan_val = 34'sd81;
            default: atan_val = 34'sd0;
        endcase
    endfunction
endpackage

@@ design/uoi_cordic.sv @@
module uoi_cordic import uoi_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cordic_req_t req,
    output cordic_rsp_t rsp
);
    localparam int NSTEP = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;

    // x,y stay within about 1.65 in Q2.30; z within 33 bits
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic [4:0]         i_reg;
    logic               busy_reg, flip_reg, done_reg;
    logic signed [33:0] xs, ys, at;
    logic [31:0]        a_adj;
    logic               flip;

    assign flip  = (req.angle[31:30] == 2'd1) || (req.angle[31:30] == 2'd2);
    assign a_adj = flip ? (req.angle + 32'h8000_0000) : req.angle;
    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign at = atan_val(i_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
                flip_reg <= flip;
                x_reg    <= CORDIC_GAIN;
                y_reg    <= '0;
                z_reg    <= {{2{a_adj[31]}}, a_adj};
            end else if (busy_reg) begin
                if (!z_reg[33]) begin
                    x_reg <= x_reg - ys; y_reg <= y_reg + xs; z_reg <= z_reg - at;
                end else begin
                    x_reg <= x_reg + ys; y_reg <= y_reg - xs; z_reg <= z_reg + at;
                end
                i_reg <= i_reg + 5'd1;
                if (i_reg == 5'(NSTEP - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.cos_v = flip_reg ? -x_reg : x_reg;
    assign rsp.sin_v = flip_reg ? -y_reg : y_reg;
endmodule

@@ design/uoi_mul.sv @@
module uoi_mul (
    input  logic               aclk,
    input  logic signed [33:0] a,
    input  logic signed [33:0] b,
    output logic signed [67:0] p
);
    // shared registered multiplier, split into 17-bit halves over two stages
    logic signed [16:0] ah, bh;
    logic        [16:0] al, bl;
    logic signed [33:0] hh_reg;
    logic signed [34:0] hl_reg, lh_reg;
    logic        [33:0] ll_reg;
    assign ah = a[33:17];
    assign bh = b[33:17];
    assign al = a[16:0];
    assign bl = b[16:0];
    always_ff @(posedge aclk) begin
        hh_reg <= ah * bh;
        hl_reg <= 35'(ah) * $signed({1'b0, bl});
        lh_reg <= $signed({1'b0, al}) * 35'(bh);
        ll_reg <= al * bl;
        p      <= (68'(hh_reg) <<< 34) + ((68'(hl_reg) + 68'(lh_reg)) <<< 17)
                  + $signed({34'd0, ll_reg});
    end
endmodule

@@ design/unicycle_odometry_integrator.sv @@
// Dead-reckoning pose integrator. Requests on s_axis are velocity commands
// (opcode 0), timer ticks (1) or enable changes (2); only an enabled tick
// yields a pose on m_axis. A command or enable is taken without leaving the
// idle state, so they can follow back to back. A tick runs the iterative
// CORDIC for the heading, then the five sequenced multiplies on the single
// shared two-stage multiplier, then the CORDIC again for the half angle,
// then the output load (ST_OUT) and a turnaround state (ST_WAIT) before
// the block is idle again. The block takes no request while a
// tick is in work; a pose still waiting on m_axis holds the next tick at
// its output stage, while commands and enables are still taken.
// Yaw is a binary phase, full scale 4 pi; position is in micrometres.
module unicycle_odometry_integrator import uoi_pkg::*; #(
    parameter int POS_WIDTH    = POS_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [1:0] opcode, [33:2] time_ms, [49:34] linear_cmd, [65:50] angular_cmd,
    // [66] enable_value, zero fill to 72
    input  logic [71:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [47:0] pos_x, [95:48] pos_y, [127:96] yaw_phase, [143:128] quat_z,
    // [159:144] quat_w, [175:160] linear_vel, [191:176] angular_vel,
    // [223:192] stamp_ms
    output logic [223:0] m_tdata
);
    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_CORD1 = 10'b0000000010,
        ST_VDT   = 10'b0000000100,
        ST_MULX  = 10'b0000001000,
        ST_MULY  = 10'b0000010000,
        ST_YAW1  = 10'b0000100000,
        ST_YAW2  = 10'b0001000000,
        ST_CORD2 = 10'b0010000000,
        ST_OUT   = 10'b0100000000,
        ST_WAIT  = 10'b1000000000
    } state_t;

    localparam int MUL_LAT = 2;

    state_t state_reg;
    logic [14:0] lin_lim_reg, ang_lim_reg;
    logic [15:0] timeout_reg, max_step_reg;
    logic [POS_WIDTH-1:0] x_reg, y_reg;
    logic [31:0] yaw_reg, tick_t_reg, cmd_t_reg, stamp_reg;
    logic signed [15:0] lin_reg, ang_reg;
    logic en_reg;
    logic [15:0] dt_reg;
    logic signed [33:0] c_reg, s_reg, vdt_reg, ma, mb;
    logic signed [67:0] mp;
    logic [1:0]  wcnt_reg;
    logic [223:0] out_reg;
    logic        mvalid_reg;
    cordic_req_t creq;
    cordic_rsp_t crsp;

    logic [1:0]  op;
    logic [31:0] t_in, diff, age;
    logic signed [16:0] lcmd, acmd, llim, alim;
    logic signed [15:0] lcl, acl;

    assign op   = s_tdata[1:0];
    assign t_in = s_tdata[33:2];
    assign lcmd = 17'($signed(s_tdata[49:34]));
    assign acmd = 17'($signed(s_tdata[65:50]));
    assign llim = $signed({2'b00, lin_lim_reg});
    assign alim = $signed({2'b00, ang_lim_reg});
    assign lcl  = (lcmd > llim) ? 16'(llim) : (lcmd < -llim) ? 16'(-llim) : 16'(lcmd);
    assign acl  = (acmd > alim) ? 16'(alim) : (acmd < -alim) ? 16'(-alim) : 16'(acmd);
    assign diff = t_in - tick_t_reg;
    assign age  = t_in - cmd_t_reg;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = out_reg;

    uoi_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .req(creq), .rsp(crsp));
    uoi_mul u_mul (.aclk(aclk), .a(ma), .b(mb), .p(mp));

    // multiplier operand select
    always_comb begin
        ma = '0; mb = '0;
        case (state_reg)
            ST_VDT:  begin ma = 34'(lin_reg); mb = {18'd0, dt_reg}; end
            ST_MULX: begin ma = c_reg; mb = vdt_reg; end
            ST_MULY: begin ma = s_reg; mb = vdt_reg; end
            ST_YAW1: begin ma = 34'(ang_reg); mb = {18'd0, dt_reg}; end
            ST_YAW2: begin ma = vdt_reg; mb = {9'd0, YAW_SCALE_Q16}; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    logic signed [67:0] rnd30, rnd16;
    assign rnd30 = (mp + (68'sd1 <<< 29)) >>> 30;
    assign rnd16 = (mp + (68'sd1 <<< 15)) >>> 16;

    function automatic logic [15:0] q15(input logic signed [33:0] v);
        logic signed [33:0] r;
        r = (v + 34'sd16384) >>> 15;
        if (r > 34'sd32767) q15 = 16'h7FFF;
        else if (r < -34'sd32768) q15 = 16'h8000;
        else q15 = r[15:0];
    endfunction

    logic [47:0] px, py;
    assign px = 48'($signed(x_reg));
    assign py = 48'($signed(y_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            lin_lim_reg <= 15'd400;  ang_lim_reg  <= 15'd1200;
            timeout_reg <= 16'd250;  max_step_reg <= 16'd100;
            x_reg <= '0; y_reg <= '0; yaw_reg <= '0;
            lin_reg <= '0; ang_reg <= '0;
            tick_t_reg <= '0; cmd_t_reg <= '0;
            en_reg <= 1'b1; mvalid_reg <= 1'b0;
            wcnt_reg <= '0;
            creq.start <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_LIN_LIMIT: lin_lim_reg  <= cfg_data[14:0];
                    REG_ANG_LIMIT: ang_lim_reg  <= cfg_data[14:0];
                    REG_TIMEOUT:   timeout_reg  <= cfg_data;
                    REG_MAX_STEP:  max_step_reg <= cfg_data;
                    default: ;
                endcase
            end
            // the output stage reloads the register itself
            if (mvalid_reg && m_tready && (state_reg != ST_OUT)) mvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (s_tvalid && s_tready) begin
                    case (op)
                        OP_CMD: begin
                            lin_reg <= lcl; ang_reg <= acl; cmd_t_reg <= t_in;
                        end
                        OP_ENABLE: begin
                            en_reg <= s_tdata[66]; lin_reg <= '0; ang_reg <= '0;
                            tick_t_reg <= t_in; cmd_t_reg <= t_in;
                        end
                        OP_TICK: if (en_reg) begin
                            if (diff[31]) dt_reg <= '0;
                            else if (diff > {16'd0, max_step_reg}) dt_reg <= max_step_reg;
                            else dt_reg <= diff[15:0];
                            tick_t_reg <= t_in;
                            stamp_reg  <= t_in;
                            if (!age[31] && age > {16'd0, timeout_reg}) begin
                                lin_reg <= '0; ang_reg <= '0;
                            end
                            creq.start <= 1'b1;
                            creq.angle <= {yaw_reg[30:0], 1'b0};
                            state_reg  <= ST_CORD1;
                        end
                        default: ;
                    endcase
                end
                ST_CORD1: begin
                    creq.start <= 1'b0;
                    if (crsp.done) begin
                        c_reg <= crsp.cos_v; s_reg <= crsp.sin_v;
                        wcnt_reg <= '0; state_reg <= ST_VDT;
                    end
                end
                ST_VDT, ST_MULX, ST_MULY, ST_YAW1, ST_YAW2: begin
                    // operands held until wcnt_reg reaches MUL_LAT and the product is taken
                    if (wcnt_reg == 2'(MUL_LAT)) begin
                        wcnt_reg <= '0;
                        case (state_reg)
                            ST_VDT:  begin vdt_reg <= mp[33:0]; state_reg <= ST_MULX; end
                            ST_MULX: begin
                                x_reg <= x_reg + rnd30[POS_WIDTH-1:0];
                                state_reg <= ST_MULY;
                            end
                            ST_MULY: begin
                                y_reg <= y_reg + rnd30[POS_WIDTH-1:0];
                                state_reg <= ST_YAW1;
                            end
                            ST_YAW1: begin vdt_reg <= mp[33:0]; state_reg <= ST_YAW2; end
                            default: begin
                                yaw_reg <= yaw_reg + rnd16[31:0];
                                creq.start <= 1'b1;
                                creq.angle <= yaw_reg + rnd16[31:0];
                                state_reg <= ST_CORD2;
                            end
                        endcase
                    end else begin
                        wcnt_reg <= wcnt_reg + 2'd1;
                    end
                end
                ST_CORD2: begin
                    creq.start <= 1'b0;
                    if (crsp.done) state_reg <= ST_OUT;
                end
                ST_OUT: if (!mvalid_reg || m_tready) begin
                    out_reg <= {stamp_reg, ang_reg, lin_reg, q15(crsp.cos_v),
                                q15(crsp.sin_v), yaw_reg, py, px};
                    mvalid_reg <= 1'b1;
                    state_reg  <= ST_WAIT;
                end
                ST_WAIT: state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
